/* hdl/retry_backoff_policy_macros.svh */
// Assertion macros shared by the retry backoff policy modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RETRY_BACKOFF_POLICY_MACROS_SVH
`define RETRY_BACKOFF_POLICY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("retry backoff policy: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("retry backoff policy: assertion failed");

`endif

/* hdl/rbp_pkg.sv */
// Shared types and constants for the retry backoff policy block.
// No dependencies; used by rbp_ctrl, rbp_dp and retry_backoff_policy.
`timescale 1ns / 1ps

package rbp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FLAGS        = 3'd0;
  localparam logic [2:0] REG_INIT_DELAY   = 3'd1;
  localparam logic [2:0] REG_GROW_FACTOR  = 3'd2;
  localparam logic [2:0] REG_MAX_WAIT     = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT  = 3'd4;
  localparam logic [2:0] REG_MAX_ELAPSED  = 3'd5;
  localparam logic [2:0] REG_CONN_MASK    = 3'd6;
  localparam logic [2:0] REG_STATUS_TABLE = 3'd7;

  // Register values after reset.
  localparam logic [4:0]  RST_FLAGS        = 5'd30;
  localparam logic [15:0] RST_INIT_DELAY   = 16'd1;
  localparam logic [7:0]  RST_GROW_FACTOR  = 8'd2;
  localparam logic [15:0] RST_MAX_WAIT     = 16'd60;
  localparam logic [15:0] RST_RETRY_LIMIT  = 16'd10;
  localparam logic [23:0] RST_MAX_ELAPSED  = 24'd600;
  localparam logic [63:0] RST_CONN_MASK    = 64'h0110_0000_1004_0000;
  localparam logic [19:0] RST_STATUS_TABLE = 20'd0;

  // Operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_FAIL  = 1'b1;

  // Error kinds.
  localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
  localparam logic [1:0] KIND_RESPONSE   = 2'd1;
  localparam logic [1:0] KIND_CONNECTION = 2'd2;

  // Delay modes (flags bits 1:0).
  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_EQUAL = 2'd2;

  // Flag bit positions.
  localparam int FLAG_COUNT_LIMIT = 2;
  localparam int FLAG_TIME_LIMIT  = 3;
  localparam int FLAG_SERVER_ERR  = 4;

  // Status codes with special handling.
  localparam logic [9:0] STATUS_THROTTLE = 10'd429;
  localparam logic [9:0] STATUS_SERVER   = 10'd500;

  // Verdict codes.
  localparam logic [2:0] VERDICT_ACCEPTED  = 3'd0;
  localparam logic [2:0] VERDICT_ATTEMPTS  = 3'd1;
  localparam logic [2:0] VERDICT_TIME      = 3'd2;
  localparam logic [2:0] VERDICT_REJECTED  = 3'd3;
  localparam logic [2:0] VERDICT_STARTED   = 3'd4;

  // The divider retires one dividend bit per cycle over a 32-bit dividend.
  localparam logic [4:0] DIV_LAST = 5'd31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic grow;      // grow and clamp the ceiling
    logic div_step;  // one restoring division step
    logic decide;    // compute the result, update state, load output
  } rbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a new word this cycle
  } rbp_sts_t;

endpackage

/* hdl/rbp_ctrl.sv */
// Controller state machine of the retry backoff policy block.
// Depends on rbp_pkg and retry_backoff_policy_macros.svh.
`timescale 1ns / 1ps
`include "retry_backoff_policy_macros.svh"

module rbp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  input  rbp_pkg::rbp_sts_t  sts,
  output rbp_pkg::rbp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GROW   = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == rbp_pkg::OP_FAIL) ? S_GROW : S_DECIDE;
        end
      end
      S_GROW: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == rbp_pkg::DIV_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.grow     = (state_r == S_GROW);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.decide   = (state_r == S_DECIDE) && sts.out_free;

  `RBP_ASSERT_NEXT(a_div_ends, (state_r == S_DIV) && (cnt_r == rbp_pkg::DIV_LAST), state_r == S_DECIDE)
  `RBP_ASSERT_NEXT(a_fail_grows, cmd.capture && (in_op == rbp_pkg::OP_FAIL), state_r == S_GROW)
  `RBP_ASSERT_NEXT(a_start_direct, cmd.capture && (in_op == rbp_pkg::OP_START), state_r == S_DECIDE)

endmodule

/* hdl/rbp_dp.sv */
// Datapath of the retry backoff policy block: configuration registers,
// operation state, ceiling growth, serial divider and output register.
// Depends on rbp_pkg and retry_backoff_policy_macros.svh.
`timescale 1ns / 1ps
`include "retry_backoff_policy_macros.svh"

module rbp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rbp_pkg::rbp_cmd_t  cmd,
  output rbp_pkg::rbp_sts_t  sts,
  input  logic               in_op,
  input  logic [1:0]         in_error_kind,
  input  logic [9:0]         in_status,
  input  logic [5:0]         in_conn_code,
  input  logic [30:0]        in_rand_req,
  input  logic [31:0]        in_now_s,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_retry,
  output logic [15:0]        out_sleep_s,
  output logic [2:0]         out_verdict,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  // Configuration registers.
  logic [4:0]  flags_r;
  logic [15:0] base_r;
  logic [7:0]  grow_r;
  logic [15:0] maxw_r;
  logic [15:0] maxa_r;
  logic [23:0] maxe_r;
  logic [63:0] mask_r;
  logic [19:0] stab_r;

  // Operation state.
  logic [15:0] ceil_r;
  logic [15:0] retries_r;
  logic [31:0] start_r;

  // Captured word.
  logic        op_r;
  logic [1:0]  kind_r;
  logic [9:0]  status_r;
  logic [5:0]  code_r;
  logic [31:0] now_r;
  logic        eq429_r;

  // Divider.
  logic [31:0] dvd_r;
  logic [15:0] rem_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        out_retry_r;
  logic [15:0] out_sleep_r;
  logic [2:0]  out_verdict_r;

  logic [1:0]  mode;
  logic        in_eq429;
  logic [23:0] prod;
  logic [15:0] ceil_grown;
  logic [16:0] trial;
  logic [16:0] trial_diff;
  logic        trial_ge;
  logic [16:0] half_sum;
  logic [15:0] sleep_calc;
  logic [31:0] elapsed;
  logic [32:0] budget_sum;
  logic        exhausted;
  logic        time_out;
  logic        table_hit;
  logic        resp_ok;
  logic [2:0]  verdict_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= rbp_pkg::RST_FLAGS;
      base_r  <= rbp_pkg::RST_INIT_DELAY;
      grow_r  <= rbp_pkg::RST_GROW_FACTOR;
      maxw_r  <= rbp_pkg::RST_MAX_WAIT;
      maxa_r  <= rbp_pkg::RST_RETRY_LIMIT;
      maxe_r  <= rbp_pkg::RST_MAX_ELAPSED;
      mask_r  <= rbp_pkg::RST_CONN_MASK;
      stab_r  <= rbp_pkg::RST_STATUS_TABLE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbp_pkg::REG_FLAGS:        flags_r <= cfg_wdata[4:0];
        rbp_pkg::REG_INIT_DELAY:   base_r  <= cfg_wdata[15:0];
        rbp_pkg::REG_GROW_FACTOR:  grow_r  <= cfg_wdata[7:0];
        rbp_pkg::REG_MAX_WAIT:     maxw_r  <= cfg_wdata[15:0];
        rbp_pkg::REG_RETRY_LIMIT:  maxa_r  <= cfg_wdata[15:0];
        rbp_pkg::REG_MAX_ELAPSED:  maxe_r  <= cfg_wdata[23:0];
        rbp_pkg::REG_CONN_MASK:    mask_r  <= cfg_wdata;
        rbp_pkg::REG_STATUS_TABLE: stab_r  <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  assign mode     = flags_r[1:0];
  assign in_eq429 = (mode == rbp_pkg::MODE_EQUAL) &&
                    (in_error_kind == rbp_pkg::KIND_RESPONSE) &&
                    (in_status == rbp_pkg::STATUS_THROTTLE);

  // Ceiling growth, clamped to max_wait.
  assign prod       = ceil_r * grow_r;
  assign ceil_grown = (prod < {8'd0, maxw_r}) ? prod[15:0] : maxw_r;

  // Restoring division step: the remainder stays below a nonzero divisor.
  assign trial      = {rem_r, dvd_r[31]};
  assign trial_ge   = (trial >= {1'b0, ceil_r});
  assign trial_diff = trial - {1'b0, ceil_r};

  // Sleep selection. A zero ceiling forces every jittered sleep to zero.
  assign half_sum = {1'b0, ceil_r} + {1'b0, rem_r};
  always_comb begin
    if (mode == rbp_pkg::MODE_CONST) begin
      sleep_calc = base_r;
    end else if (ceil_r == 16'd0) begin
      sleep_calc = 16'd0;
    end else if (eq429_r) begin
      sleep_calc = half_sum[16:1];
    end else begin
      sleep_calc = rem_r;
    end
  end

  assign elapsed    = now_r - start_r;
  assign budget_sum = {1'b0, elapsed} + {17'd0, sleep_calc};
  assign exhausted  = flags_r[rbp_pkg::FLAG_COUNT_LIMIT] && (retries_r >= maxa_r);
  assign time_out   = flags_r[rbp_pkg::FLAG_TIME_LIMIT] && (budget_sum >= {9'd0, maxe_r});
  assign table_hit  = ((stab_r[9:0] != 10'd0) && (stab_r[9:0] == status_r)) ||
                      ((stab_r[19:10] != 10'd0) && (stab_r[19:10] == status_r));
  assign resp_ok    = (flags_r[rbp_pkg::FLAG_SERVER_ERR] &&
                       (status_r >= rbp_pkg::STATUS_SERVER)) ||
                      table_hit ||
                      ((mode == rbp_pkg::MODE_EQUAL) &&
                       (status_r == rbp_pkg::STATUS_THROTTLE));

  always_comb begin
    if (exhausted) begin
      verdict_calc = rbp_pkg::VERDICT_ATTEMPTS;
    end else if (time_out) begin
      verdict_calc = rbp_pkg::VERDICT_TIME;
    end else begin
      case (kind_r)
        rbp_pkg::KIND_UNKNOWN: begin
          verdict_calc = rbp_pkg::VERDICT_ACCEPTED;
        end
        rbp_pkg::KIND_RESPONSE: begin
          verdict_calc = resp_ok ? rbp_pkg::VERDICT_ACCEPTED : rbp_pkg::VERDICT_REJECTED;
        end
        rbp_pkg::KIND_CONNECTION: begin
          verdict_calc = mask_r[code_r] ? rbp_pkg::VERDICT_ACCEPTED
                                        : rbp_pkg::VERDICT_REJECTED;
        end
        default: verdict_calc = rbp_pkg::VERDICT_REJECTED;
      endcase
    end
  end

  // Captured word and divider.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      kind_r   <= in_error_kind;
      status_r <= in_status;
      code_r   <= in_conn_code;
      now_r    <= in_now_s;
      eq429_r  <= in_eq429;
      dvd_r    <= in_eq429 ? {in_rand_req, 1'b0} : {1'b0, in_rand_req};
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= trial_ge ? trial_diff[15:0] : trial[15:0];
    end
  end

  // Operation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r    <= rbp_pkg::RST_INIT_DELAY;
      retries_r <= '0;
      start_r   <= '0;
    end else if (cmd.grow) begin
      ceil_r <= ceil_grown;
    end else if (cmd.decide) begin
      if (op_r == rbp_pkg::OP_START) begin
        ceil_r    <= base_r;
        retries_r <= '0;
        start_r   <= now_r;
      end else if (!exhausted && flags_r[rbp_pkg::FLAG_COUNT_LIMIT]) begin
        retries_r <= retries_r + 16'd1;
      end
    end
  end

  // Output register.
  assign out_valid_nxt = cmd.decide ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (op_r == rbp_pkg::OP_START) begin
        out_retry_r   <= 1'b0;
        out_sleep_r   <= 16'd0;
        out_verdict_r <= rbp_pkg::VERDICT_STARTED;
      end else begin
        out_retry_r   <= (verdict_calc == rbp_pkg::VERDICT_ACCEPTED);
        out_sleep_r   <= sleep_calc;
        out_verdict_r <= verdict_calc;
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_retry    = out_retry_r;
  assign out_sleep_s  = out_sleep_r;
  assign out_verdict  = out_verdict_r;

  `RBP_ASSERT_SAME(a_retry_matches, out_valid_r, out_retry_r == (out_verdict_r == 3'd0))
  `RBP_ASSERT_SAME(a_jitter_bound, cmd.decide && op_r && (mode != 2'd0), sleep_calc <= ceil_r)
  `RBP_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_verdict_r))

endmodule

/* hdl/retry_backoff_policy.sv */
// Top level of the retry backoff policy block.
// Depends on rbp_pkg, rbp_ctrl, rbp_dp and retry_backoff_policy_macros.svh.
`timescale 1ns / 1ps

// Usage: each input word is either a start (op 0) or a failure report (op 1)
// for the single operation that the block tracks. The input channel takes a
// word when in_valid is high and in_stall is low; the result channel offers
// one word per input word, taken when out_valid is high and out_stall is low.
// A start word goes from the idle state to the decide state, which loads its
// result: retry 0, sleep 0, verdict started. A failure word passes through the
// grow state, which grows and clamps the ceiling, the divide state, which runs
// the bit-serial remainder for the jitter, and the decide state, which applies
// the retry checks and loads the output register. The block works on one word
// at a time and takes the next word after the previous result is loaded.
// When the receiver stalls, the result waits in the output register and the
// block still takes the next input word; that word's result is held back
// until the register is free, and in_stall stays high meanwhile.
// Configuration writes use cfg_valid, cfg_ready (always high), cfg_index and
// cfg_wdata, and are meant to happen only while the block is idle.
// Reset (synchronous, active low) restores the configuration registers to
// their defaults, sets the ceiling to 1, clears the retry count and the start
// time, and empties the output register.
module retry_backoff_policy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_error_kind,
  input  logic [9:0]  in_status,
  input  logic [5:0]  in_conn_code,
  input  logic [30:0] in_rand_req,
  input  logic [31:0] in_now_s,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_retry,
  output logic [15:0] out_sleep_s,
  output logic [2:0]  out_verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Commands flow from the controller to the datapath, status flows back.
  rbp_pkg::rbp_cmd_t cmd;
  rbp_pkg::rbp_sts_t sts;

  // The register file accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  // The controller owns the input handshake and sequences the divider.
  rbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds configuration, operation state and the output word.
  rbp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_error_kind (in_error_kind),
    .in_status     (in_status),
    .in_conn_code  (in_conn_code),
    .in_rand_req   (in_rand_req),
    .in_now_s      (in_now_s),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_retry     (out_retry),
    .out_sleep_s   (out_sleep_s),
    .out_verdict   (out_verdict),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

endmodule
